[sv/pfhm_pkg.sv]
package pfhm_pkg;

    localparam int FRAMES      = 1024;
    localparam int FRAME_W     = 10;
    localparam int PTR_W       = FRAME_W + 1;
    localparam int PAGE_W      = 31;
    localparam int DEF_BUCKETS = 1024;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(FRAMES);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;

endpackage

[sv/pfhm_bucket_mod.sv]
module pfhm_bucket_mod
    import pfhm_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [PAGE_W-1:0]          i_page,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int          BW      = $clog2(BUCKETS);
    localparam bit          IS_POW2 = (BUCKETS == (1 << BW));
    localparam int          SH      = PAGE_W + BW;
    localparam int          PW      = PAGE_W + 32;
    localparam int          QW      = PW - SH;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0] RECIP   = RECIP64[31:0];

    logic              r_s1;
    logic              r_s2;
    logic              r_done;
    logic [PAGE_W-1:0] r_page;
    logic [QW-1:0]     r_quo;
    logic [BW-1:0]     r_rem;
    logic [PW-1:0]     w_prod;
    logic [PAGE_W-1:0] w_back;
    logic [PAGE_W-1:0] w_diff;

    // quotient by reciprocal multiply, then take the remainder
    assign w_prod = PW'(r_page) * PW'(RECIP);
    assign w_back = PAGE_W'(r_quo) * PAGE_W'(BUCKETS);
    assign w_diff = r_page - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start && !IS_POW2;
            r_s2   <= r_s1;
            r_done <= (i_start && IS_POW2) || r_s2;
            if (i_start) begin
                r_page <= i_page;
                if (IS_POW2) begin
                    r_rem <= i_page[BW-1:0];
                end
            end
            if (r_s1) begin
                r_quo <= w_prod[PW-1:SH];
            end
            if (r_s2) begin
                r_rem <= w_diff[BW-1:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

[sv/page_to_frame_hash_map.sv]
// Page-to-frame hash map. A command word is taken when start is high and busy
// is low; exactly one result word follows, shown for one cycle with o_valid
// high in the cycle busy falls, and it must be taken then. After reset the
// block clears its bucket heads and frame-used flags, one address a cycle, over
// max(BUCKETS, 1024) addresses with busy high. An insert passes through the
// hash, head-read and dispatch states; a lookup or remove then walks the chain,
// each entry taking one memory read and one page compare, until a match or the end.
// When BUCKETS is not a power of two, the bucket index comes from a reciprocal
// multiply followed by a registered multiply and subtract, lengthening every command.
module page_to_frame_hash_map
    import pfhm_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [PAGE_W-1:0]  i_page_id,
    input  logic [FRAME_W-1:0] i_frame_id,
    input  logic               i_write_mark,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [FRAME_W-1:0] o_found_frame,
    output logic               o_found_write_mark
);

    localparam int BW   = $clog2(BUCKETS);
    localparam int MAXD = (BUCKETS > FRAMES) ? BUCKETS : FRAMES;
    localparam int CW   = $clog2(MAXD);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HREAD,
        S_DISPATCH,
        S_WAIT,
        S_CMP
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_clr;
    logic [1:0]         r_cmd;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_wmark;
    logic [PTR_W-1:0]   r_cur;
    logic [PTR_W-1:0]   r_prev;
    logic               r_valid;
    logic [1:0]         r_status;
    logic [FRAME_W-1:0] r_ff;
    logic               r_fw;

    logic [PTR_W-1:0]  r_head_mem [BUCKETS];
    logic              r_used_mem [FRAMES];
    logic [PAGE_W:0]   r_ent_mem  [FRAMES];
    logic [PTR_W-1:0]  r_next_mem [FRAMES];

    logic [PTR_W-1:0]  r_head_q;
    logic              r_used_q;
    logic [PAGE_W:0]   r_ent_q;
    logic [PTR_W-1:0]  r_next_q;

    logic               w_accept;
    logic               w_hash_done;
    logic [BW-1:0]      w_bucket;
    logic               w_match;

    logic               head_we;
    logic [BW-1:0]      head_waddr;
    logic [PTR_W-1:0]   head_wdata;
    logic               used_we;
    logic [FRAME_W-1:0] used_waddr;
    logic               used_wdata;
    logic               ent_we;
    logic               next_we;
    logic [FRAME_W-1:0] next_waddr;
    logic [PTR_W-1:0]   next_wdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_match  = (r_ent_q[PAGE_W:1] == r_page);

    pfhm_bucket_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_page   (i_page_id),
        .o_done   (w_hash_done),
        .o_bucket (w_bucket)
    );

    always_comb begin
        head_we    = 1'b0;
        head_waddr = w_bucket;
        head_wdata = NIL;
        used_we    = 1'b0;
        used_waddr = r_frame;
        used_wdata = 1'b0;
        ent_we     = 1'b0;
        next_we    = 1'b0;
        next_waddr = r_frame;
        next_wdata = r_head_q;
        case (r_state)
            S_CLEAR: begin
                head_we    = ({1'b0, r_clr} < (CW + 1)'(BUCKETS));
                head_waddr = r_clr[BW-1:0];
                head_wdata = NIL;
                used_we    = ({1'b0, r_clr} < (CW + 1)'(FRAMES));
                used_waddr = r_clr[FRAME_W-1:0];
                used_wdata = 1'b0;
            end
            S_DISPATCH: begin
                if (r_cmd == CMD_INSERT && !r_used_q) begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, r_frame};
                    used_we    = 1'b1;
                    used_wdata = 1'b1;
                    ent_we     = 1'b1;
                    next_we    = 1'b1;
                end
            end
            S_CMP: begin
                if (w_match && r_cmd == CMD_REMOVE) begin
                    used_we    = 1'b1;
                    used_waddr = r_cur[FRAME_W-1:0];
                    used_wdata = 1'b0;
                    if (r_prev[FRAME_W]) begin
                        head_we    = 1'b1;
                        head_wdata = r_next_q;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_prev[FRAME_W-1:0];
                        next_wdata = r_next_q;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_waddr] <= head_wdata;
        end
        r_head_q <= r_head_mem[w_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_waddr] <= used_wdata;
        end
        r_used_q <= r_used_mem[r_frame];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[r_frame] <= {r_page, r_wmark};
        end
        r_ent_q <= r_ent_mem[r_cur[FRAME_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        r_next_q <= r_next_mem[r_cur[FRAME_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(MAXD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_command;
                        r_page  <= i_page_id;
                        r_frame <= i_frame_id;
                        r_wmark <= i_write_mark;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_HREAD;
                    end
                end
                S_HREAD: begin
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_status <= ST_OK;
                    r_ff     <= '0;
                    r_fw     <= 1'b0;
                    r_cur    <= r_head_q;
                    r_prev   <= NIL;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_used_q) begin
                                r_status <= ST_OCCUPIED;
                            end
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        CMD_LOOKUP, CMD_REMOVE: begin
                            if (r_head_q[FRAME_W]) begin
                                r_status <= ST_MISS;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_WAIT;
                            end
                        end
                        default: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_WAIT: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_match) begin
                        r_status <= ST_OK;
                        r_ff     <= r_cur[FRAME_W-1:0];
                        r_fw     <= r_ent_q[0];
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= r_next_q;
                        if (r_next_q[FRAME_W]) begin
                            r_status <= ST_MISS;
                            r_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_found_frame      = r_ff;
    assign o_found_write_mark = r_fw;

endmodule

[tb/page_to_frame_hash_map_tb.sv]
`timescale 1ns / 100ps

module page_to_frame_hash_map_tb;
    import pfhm_pkg::*;

    localparam int BUCKET_COUNT = DEF_BUCKETS;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_ITEMS = 1030;
    localparam int FRAME_SPAN   = 128;
    localparam int POOL_SIZE    = 48;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               wmark;
    } t_map_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_command = CMD_LOOKUP;
    logic [PAGE_W-1:0]  i_page_id = '0;
    logic [FRAME_W-1:0] i_frame_id = '0;
    logic               i_write_mark = 1'b0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [FRAME_W-1:0] o_found_frame;
    logic               o_found_write_mark;

    page_to_frame_hash_map #(
        .BUCKETS(BUCKET_COUNT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_page_id          (i_page_id),
        .i_frame_id         (i_frame_id),
        .i_write_mark       (i_write_mark),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_found_frame      (o_found_frame),
        .o_found_write_mark (o_found_write_mark)
    );

    logic [PTR_W-1:0]  head_of_bucket [BUCKET_COUNT];
    logic [PAGE_W-1:0] page_of_frame  [FRAMES];
    logic [PTR_W-1:0]  next_of_frame  [FRAMES];
    logic              mark_of_frame  [FRAMES];
    logic              frame_in_use   [FRAMES];

    logic [PAGE_W-1:0] page_pool [POOL_SIZE];
    t_map_reply        awaited_replies [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    bit                burst_mode = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int want, int got);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                     what, want, got, cycle_count);
        mismatch_count++;
    endtask

    function automatic t_map_reply predict_map_command(t_cmd cmd, logic [PAGE_W-1:0] page,
                                                       logic [FRAME_W-1:0] frame,
                                                       logic wmark);
        t_map_reply       reply;
        logic [PTR_W-1:0] cur;
        logic [PTR_W-1:0] prev_frame;
        int               bucket;
        bit               hit;
        reply = '0;
        reply.status = ST_OK;
        bucket = int'(page % BUCKET_COUNT);
        if (cmd == CMD_INSERT) begin
            if (frame_in_use[frame]) begin
                reply.status = ST_OCCUPIED;
            end else begin
                page_of_frame[frame]   = page;
                mark_of_frame[frame]   = wmark;
                next_of_frame[frame]   = head_of_bucket[bucket];
                frame_in_use[frame]    = 1'b1;
                head_of_bucket[bucket] = {1'b0, frame};
            end
        end else if (cmd == CMD_LOOKUP || cmd == CMD_REMOVE) begin
            cur = head_of_bucket[bucket];
            prev_frame = NIL;
            hit = 1'b0;
            while (!hit && cur != NIL) begin
                if (page_of_frame[cur[FRAME_W-1:0]] == page) begin
                    hit = 1'b1;
                end else begin
                    prev_frame = cur;
                    cur = next_of_frame[cur[FRAME_W-1:0]];
                end
            end
            if (!hit) begin
                reply.status = ST_MISS;
            end else begin
                reply.frame = cur[FRAME_W-1:0];
                reply.wmark = mark_of_frame[cur[FRAME_W-1:0]];
                if (cmd == CMD_REMOVE) begin
                    if (prev_frame == NIL)
                        head_of_bucket[bucket] = next_of_frame[cur[FRAME_W-1:0]];
                    else
                        next_of_frame[prev_frame[FRAME_W-1:0]] =
                            next_of_frame[cur[FRAME_W-1:0]];
                    next_of_frame[cur[FRAME_W-1:0]] = NIL;
                    frame_in_use[cur[FRAME_W-1:0]]  = 1'b0;
                end
            end
        end
        return reply;
    endfunction

    // hold start high across back-to-back words; drop it only for a gap
    task automatic send_command(t_cmd cmd, logic [PAGE_W-1:0] page,
                                logic [FRAME_W-1:0] frame, logic wmark);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_page_id    <= page;
        i_frame_id   <= frame;
        i_write_mark <= wmark;
        do @(posedge i_clk); while (busy !== 1'b0);
        awaited_replies.push_back(predict_map_command(cmd, page, frame, wmark));
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_replies
        t_map_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected result word", 0, 1);
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_found_frame !== want.frame)
                    report_mismatch("found_frame", want.frame, o_found_frame);
                if (o_found_write_mark !== want.wmark)
                    report_mismatch("found_write_mark", want.wmark, o_found_write_mark);
            end
        end
    end

    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        int f;
        r = $urandom_range(0, 99);
        f = $urandom_range(0, FRAME_SPAN - 1);
        if (r < 10)
            return PAGE_W'($urandom());
        if (r < 55 || !frame_in_use[f])
            return page_pool[$urandom_range(0, POOL_SIZE - 1)];
        return page_of_frame[f];
    endfunction

    task automatic test_empty_map();
        send_command(CMD_LOOKUP, '0, '0, 1'b0);
        send_command(CMD_REMOVE, PAGE_MAX, FRAME_W'(FRAMES - 1), 1'b1);
    endtask

    task automatic test_insert_and_lookup();
        send_command(CMD_INSERT, '0, '0, 1'b0);
        send_command(CMD_INSERT, PAGE_MAX, FRAME_W'(FRAMES - 1), 1'b1);
        send_command(CMD_INSERT, PAGE_W'(5), '0, 1'b1);
        send_command(CMD_LOOKUP, '0, '0, 1'b0);
        send_command(CMD_LOOKUP, PAGE_MAX, '0, 1'b0);
        send_command(CMD_INSERT, PAGE_W'(32'h2AAA_AAAA), FRAME_W'(10'h2AA), 1'b1);
        send_command(CMD_INSERT, PAGE_W'(32'h5555_5555), FRAME_W'(10'h155), 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(32'h2AAA_AAAA), '0, 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(32'h5555_5555), FRAME_W'(10'h3FF), 1'b1);
    endtask

    task automatic test_chain_order();
        send_command(CMD_INSERT, PAGE_W'(1024), FRAME_W'(1), 1'b1);
        send_command(CMD_INSERT, PAGE_W'(2048), FRAME_W'(2), 1'b0);
        send_command(CMD_INSERT, PAGE_W'(1024), FRAME_W'(3), 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(1024), '0, 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(3072), '0, 1'b0);
    endtask

    task automatic test_remove_positions();
        send_command(CMD_REMOVE, PAGE_W'(1024), '0, 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(1024), '0, 1'b0);
        send_command(CMD_REMOVE, PAGE_W'(1024), '0, 1'b0);
        send_command(CMD_LOOKUP, '0, '0, 1'b0);
        send_command(CMD_REMOVE, '0, '0, 1'b0);
        send_command(CMD_LOOKUP, PAGE_W'(2048), '0, 1'b0);
        send_command(CMD_REMOVE, PAGE_W'(1024), '0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int   r;
        t_cmd cmd;
        logic [FRAME_W-1:0] frame;
        page_pool[0] = '0;
        page_pool[POOL_SIZE - 1] = PAGE_MAX;
        for (int i = 1; i < POOL_SIZE - 1; i++) begin
            if (i < 16)
                page_pool[i] = PAGE_W'(7 + i * BUCKET_COUNT);
            else if (i < 32)
                page_pool[i] = PAGE_W'($urandom());
            else
                page_pool[i] = PAGE_W'($urandom_range(0, 4 * BUCKET_COUNT));
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (i % 256 == 255)
                wait_for_replies();
            r = $urandom_range(0, 99);
            if (r < 35)
                cmd = CMD_INSERT;
            else if (r < 70)
                cmd = CMD_LOOKUP;
            else
                cmd = CMD_REMOVE;
            if (cmd == CMD_INSERT && $urandom_range(0, 19) != 0)
                frame = FRAME_W'($urandom_range(0, FRAME_SPAN - 1));
            else
                frame = FRAME_W'($urandom());
            send_command(cmd, pick_page(), frame, 1'($urandom()));
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < BUCKET_COUNT; b++)
            head_of_bucket[b] = NIL;
        for (int f = 0; f < FRAMES; f++) begin
            page_of_frame[f] = '0;
            next_of_frame[f] = NIL;
            mark_of_frame[f] = 1'b0;
            frame_in_use[f]  = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_map();
        test_insert_and_lookup();
        test_chain_order();
        test_remove_positions();
        wait_for_replies();
        test_random_traffic();

        wait_for_replies();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/pfhm_pkg.sv
sv/pfhm_bucket_mod.sv
sv/page_to_frame_hash_map.sv
tb/page_to_frame_hash_map_tb.sv
